// ----- rtl/fqd_pkg.sv -----
package fqd_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int HANDLE_W = 16;
  localparam int SIZE_W = 24;
  localparam int FORMAT_W = 8;
  localparam int TOTAL_W = 32;

  localparam logic [2:0] CMD_PUSH        = 3'd0;
  localparam logic [2:0] CMD_POP_OLDEST  = 3'd1;
  localparam logic [2:0] CMD_POP_LATEST  = 3'd2;
  localparam logic [2:0] CMD_SET_FORMAT  = 3'd3;
  localparam logic [2:0] CMD_READ_CHANGE = 3'd4;

  localparam logic [1:0] REG_DROP_LIMIT = 2'd0;
  localparam logic [1:0] REG_DROP_MODE  = 2'd1;

  localparam logic [1:0] MODE_BYTES  = 2'd1;
  localparam logic [1:0] MODE_FRAMES = 2'd2;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } desc_t;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] retreat(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

endpackage

// ----- rtl/fqd_store.sv -----
module fqd_store (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [fqd_pkg::PTR_W-1:0] wr_addr,
  input  fqd_pkg::desc_t           wr_data,
  input  logic [fqd_pkg::PTR_W-1:0] rd_addr,
  output fqd_pkg::desc_t           rd_data
);

  fqd_pkg::desc_t mem [fqd_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/frame_queue_drop_oldest.sv -----
// Queue of frame descriptors (16-bit handle, 24-bit size) in a 64-entry ring with frame
// and byte totals. One item is worked at a time: set format, read changed and unknown
// codes go from accept straight to the finish state; a pop passes its pop state and a
// push the drop check. Each frame dropped by the limit adds a drop state: one store read
// plus the totals update. Pop latest reads only the newest entry and empties the queue.
// Results sit in an output register, so the next item is accepted while a result waits.
// Configuration writes are always ready and must only come while the block is idle.
module frame_queue_drop_oldest (
  input  logic                           clk,
  input  logic                           rst,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [31:0]                    cfg_data,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     command,
  input  logic [fqd_pkg::HANDLE_W-1:0]   frame_handle,
  input  logic [fqd_pkg::SIZE_W-1:0]     frame_size,
  input  logic [fqd_pkg::FORMAT_W-1:0]   new_format,

  output logic                           res_valid,
  input  logic                           res_stall,
  output logic                           out_valid,
  output logic [fqd_pkg::HANDLE_W-1:0]   out_handle,
  output logic [fqd_pkg::SIZE_W-1:0]     out_size,
  output logic                           changed_flag,
  output logic                           queue_empty,
  output logic [fqd_pkg::CNT_W-1:0]      queued_frames,
  output logic [fqd_pkg::TOTAL_W-1:0]    queued_bytes,
  output logic [fqd_pkg::CNT_W-1:0]      dropped_now,
  output logic [fqd_pkg::TOTAL_W-1:0]    dropped_total,
  output logic                           overflow
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_DROP   = 3'd2;
  localparam logic [2:0] ST_POP    = 3'd3;
  localparam logic [2:0] ST_POPL   = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state;

  logic [31:0] drop_limit;
  logic [1:0]  drop_mode;

  logic [fqd_pkg::PTR_W-1:0]    head;
  logic [fqd_pkg::PTR_W-1:0]    tail;
  logic [fqd_pkg::CNT_W-1:0]    frame_total;
  logic [fqd_pkg::TOTAL_W-1:0]  byte_total;
  logic [fqd_pkg::FORMAT_W-1:0] current_format;
  logic                         format_changed;
  logic [fqd_pkg::TOTAL_W-1:0]  drop_counter;

  // per-item working registers
  logic                         item_valid;
  logic [fqd_pkg::HANDLE_W-1:0] item_handle;
  logic [fqd_pkg::SIZE_W-1:0]   item_size;
  logic                         item_changed;
  logic [fqd_pkg::CNT_W-1:0]    item_dropped;
  logic                         item_overflow;

  logic                      accept;
  logic                      store_full;
  logic                      wr_en;
  logic [fqd_pkg::PTR_W-1:0] rd_addr;
  fqd_pkg::desc_t            wr_data;
  fqd_pkg::desc_t            rd_data;
  logic                      need_drop;

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign store_full = (frame_total == fqd_pkg::CNT_W'(fqd_pkg::QUEUE_DEPTH));
  assign wr_en      = accept && (command == fqd_pkg::CMD_PUSH) && !store_full;
  assign wr_data    = '{handle: frame_handle, size: frame_size};

  always_comb begin
    rd_addr = head;
    if (state == ST_IDLE && command == fqd_pkg::CMD_POP_LATEST) begin
      rd_addr = fqd_pkg::retreat(tail);
    end
  end

  always_comb begin
    need_drop = 1'b0;
    if (drop_limit != '0 && frame_total != '0) begin
      if (drop_mode == fqd_pkg::MODE_BYTES) begin
        need_drop = byte_total > drop_limit;
      end else if (drop_mode == fqd_pkg::MODE_FRAMES) begin
        need_drop = 32'(frame_total) > drop_limit;
      end
    end
  end

  fqd_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_limit <= '0;
      drop_mode  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fqd_pkg::REG_DROP_LIMIT: drop_limit <= cfg_data;
        fqd_pkg::REG_DROP_MODE:  drop_mode  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      head           <= '0;
      tail           <= '0;
      frame_total    <= '0;
      byte_total     <= '0;
      current_format <= '0;
      format_changed <= 1'b1;
      drop_counter   <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (res_valid && !res_stall && state != ST_FINISH) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            item_valid    <= 1'b0;
            item_handle   <= '0;
            item_size     <= '0;
            item_changed  <= format_changed;
            item_dropped  <= '0;
            item_overflow <= 1'b0;
            state         <= ST_FINISH;
            case (command)
              fqd_pkg::CMD_PUSH: begin
                if (store_full) begin
                  item_overflow <= 1'b1;
                end else begin
                  tail        <= fqd_pkg::advance(tail);
                  frame_total <= frame_total + 1'b1;
                  byte_total  <= byte_total + 32'(frame_size);
                  state       <= ST_CHECK;
                end
              end
              fqd_pkg::CMD_POP_OLDEST: begin
                if (frame_total != '0) begin
                  state <= ST_POP;
                end
              end
              fqd_pkg::CMD_POP_LATEST: begin
                if (frame_total != '0) begin
                  state <= ST_POPL;
                end else begin
                  head <= '0;
                  tail <= '0;
                end
              end
              fqd_pkg::CMD_SET_FORMAT: begin
                if (new_format != current_format) begin
                  head           <= '0;
                  tail           <= '0;
                  frame_total    <= '0;
                  byte_total     <= '0;
                  format_changed <= 1'b1;
                  current_format <= new_format;
                end
              end
              fqd_pkg::CMD_READ_CHANGE: begin
                format_changed <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_CHECK: begin
          // head read is issued this cycle, data lands in ST_DROP
          if (need_drop) begin
            state <= ST_DROP;
          end else begin
            drop_counter <= drop_counter + 32'(item_dropped);
            state        <= ST_FINISH;
          end
        end
        ST_DROP: begin
          byte_total   <= byte_total - 32'(rd_data.size);
          frame_total  <= frame_total - 1'b1;
          head         <= fqd_pkg::advance(head);
          item_dropped <= item_dropped + 1'b1;
          state        <= ST_CHECK;
        end
        ST_POP: begin
          item_valid  <= 1'b1;
          item_handle <= rd_data.handle;
          item_size   <= rd_data.size;
          byte_total  <= byte_total - 32'(rd_data.size);
          frame_total <= frame_total - 1'b1;
          head        <= fqd_pkg::advance(head);
          state       <= ST_FINISH;
        end
        ST_POPL: begin
          item_valid  <= 1'b1;
          item_handle <= rd_data.handle;
          item_size   <= rd_data.size;
          head        <= '0;
          tail        <= '0;
          frame_total <= '0;
          byte_total  <= '0;
          state       <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!res_valid || !res_stall)) begin
      out_valid     <= item_valid;
      out_handle    <= item_handle;
      out_size      <= item_size;
      changed_flag  <= item_changed;
      queue_empty   <= (frame_total == '0);
      queued_frames <= frame_total;
      queued_bytes  <= byte_total;
      dropped_now   <= item_dropped;
      dropped_total <= drop_counter;
      overflow      <= item_overflow;
    end
  end

  a_frames_bounded: assert property (@(posedge clk) disable iff (rst)
    frame_total <= fqd_pkg::CNT_W'(fqd_pkg::QUEUE_DEPTH))
    else $error("frame count above queue depth");

  a_empty_no_bytes: assert property (@(posedge clk) disable iff (rst)
    (frame_total == '0) |-> (byte_total == '0))
    else $error("bytes held with no frames queued");

  a_ring_consistent: assert property (@(posedge clk) disable iff (rst)
    ((32'(head) + 32'(frame_total)) % fqd_pkg::QUEUE_DEPTH) == 32'(tail))
    else $error("head, tail and frame count disagree");

  a_refused_no_drop: assert property (@(posedge clk) disable iff (rst)
    (res_valid && overflow) |-> (dropped_now == '0 && !out_valid))
    else $error("refused push reports drops or a frame");

endmodule

// ----- sim/frame_queue_drop_oldest_test.sv -----
`timescale 1ns / 1ps

module frame_queue_drop_oldest_test;

  localparam logic [2:0] CMD_RESERVED_LO = 3'd5;
  localparam logic [2:0] CMD_RESERVED_HI = 3'd7;
  localparam logic [1:0] MODE_OFF      = 2'd0;
  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 150;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [2:0]                   command;
    logic [fqd_pkg::HANDLE_W-1:0] handle;
    logic [fqd_pkg::SIZE_W-1:0]   size;
    logic [fqd_pkg::FORMAT_W-1:0] fmt;
  } cmd_item_t;

  typedef struct packed {
    logic                         out_valid;
    logic [fqd_pkg::HANDLE_W-1:0] handle;
    logic [fqd_pkg::SIZE_W-1:0]   size;
    logic                         changed;
    logic                         empty;
    logic [fqd_pkg::CNT_W-1:0]    frames;
    logic [fqd_pkg::TOTAL_W-1:0]  bytes;
    logic [fqd_pkg::CNT_W-1:0]    dropped;
    logic [fqd_pkg::TOTAL_W-1:0]  drop_count;
    logic                         overflow;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [1:0]                   cfg_index = fqd_pkg::REG_DROP_LIMIT;
  logic [31:0]                  cfg_data = '0;

  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [2:0]                   command = fqd_pkg::CMD_PUSH;
  logic [fqd_pkg::HANDLE_W-1:0] frame_handle = '0;
  logic [fqd_pkg::SIZE_W-1:0]   frame_size = '0;
  logic [fqd_pkg::FORMAT_W-1:0] new_format = '0;

  logic                         res_valid;
  logic                         res_stall = 1'b0;
  logic                         out_valid;
  logic [fqd_pkg::HANDLE_W-1:0] out_handle;
  logic [fqd_pkg::SIZE_W-1:0]   out_size;
  logic                         changed_flag;
  logic                         queue_empty;
  logic [fqd_pkg::CNT_W-1:0]    queued_frames;
  logic [fqd_pkg::TOTAL_W-1:0]  queued_bytes;
  logic [fqd_pkg::CNT_W-1:0]    dropped_now;
  logic [fqd_pkg::TOTAL_W-1:0]  dropped_total;
  logic                         overflow;

  frame_queue_drop_oldest dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .frame_handle(frame_handle), .frame_size(frame_size), .new_format(new_format),
    .res_valid(res_valid), .res_stall(res_stall), .out_valid(out_valid),
    .out_handle(out_handle), .out_size(out_size), .changed_flag(changed_flag),
    .queue_empty(queue_empty), .queued_frames(queued_frames), .queued_bytes(queued_bytes),
    .dropped_now(dropped_now), .dropped_total(dropped_total), .overflow(overflow)
  );

  always #4 clk = ~clk;

  // queue model
  logic [fqd_pkg::HANDLE_W-1:0] ring_handle [fqd_pkg::QUEUE_DEPTH];
  logic [fqd_pkg::SIZE_W-1:0]   ring_size [fqd_pkg::QUEUE_DEPTH];
  logic [fqd_pkg::PTR_W-1:0]    rd_slot = '0;
  logic [fqd_pkg::PTR_W-1:0]    wr_slot = '0;
  int                           held_frames = 0;
  logic [fqd_pkg::TOTAL_W-1:0]  held_bytes = '0;
  logic [fqd_pkg::FORMAT_W-1:0] fmt_now = '0;
  logic                         fmt_flag = 1'b1;
  logic [fqd_pkg::TOTAL_W-1:0]  drops_so_far = '0;
  logic [31:0]                  budget = '0;
  logic [1:0]                   budget_mode = MODE_OFF;

  cmd_item_t cmd_backlog[$];
  status_t   due_status[$];
  cmd_item_t on_wire;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int fail_count = 0;
  int cycle_count = 0;

  function automatic fqd_pkg::desc_t drop_oldest();
    fqd_pkg::desc_t d;
    d.handle = ring_handle[rd_slot];
    d.size = ring_size[rd_slot];
    held_bytes = held_bytes - 32'(d.size);
    held_frames--;
    rd_slot = fqd_pkg::advance(rd_slot);
    return d;
  endfunction

  function automatic void clear_ring();
    rd_slot = '0;
    wr_slot = '0;
    held_frames = 0;
    held_bytes = '0;
  endfunction

  function automatic status_t apply_command(input cmd_item_t it);
    status_t                   st;
    fqd_pkg::desc_t            d;
    logic [fqd_pkg::PTR_W-1:0] last;
    st = '0;
    st.changed = fmt_flag;
    case (it.command)
      fqd_pkg::CMD_PUSH: begin
        if (held_frames == fqd_pkg::QUEUE_DEPTH) begin
          st.overflow = 1'b1;
        end else begin
          ring_handle[wr_slot] = it.handle;
          ring_size[wr_slot] = it.size;
          wr_slot = fqd_pkg::advance(wr_slot);
          held_frames++;
          held_bytes = held_bytes + 32'(it.size);
          if (budget != 0 && budget_mode == fqd_pkg::MODE_BYTES) begin
            // an oversized frame goes too, leaving nothing held
            while (held_bytes > budget && held_frames > 0) begin
              void'(drop_oldest());
              st.dropped++;
            end
          end else if (budget != 0 && budget_mode == fqd_pkg::MODE_FRAMES) begin
            while (held_frames > budget && held_frames > 0) begin
              void'(drop_oldest());
              st.dropped++;
            end
          end
          drops_so_far = drops_so_far + 32'(st.dropped);
        end
      end
      fqd_pkg::CMD_POP_OLDEST: begin
        if (held_frames > 0) begin
          d = drop_oldest();
          st.out_valid = 1'b1;
          st.handle = d.handle;
          st.size = d.size;
        end
      end
      fqd_pkg::CMD_POP_LATEST: begin
        if (held_frames > 0) begin
          last = fqd_pkg::retreat(wr_slot);
          st.out_valid = 1'b1;
          st.handle = ring_handle[last];
          st.size = ring_size[last];
        end
        clear_ring();
      end
      fqd_pkg::CMD_SET_FORMAT: begin
        if (it.fmt != fmt_now) begin
          clear_ring();
          fmt_flag = 1'b1;
          fmt_now = it.fmt;
        end
      end
      fqd_pkg::CMD_READ_CHANGE: fmt_flag = 1'b0;
      default: ;
    endcase
    st.empty = (held_frames == 0);
    st.frames = fqd_pkg::CNT_W'(held_frames);
    st.bytes = held_bytes;
    st.drop_count = drops_so_far;
    return st;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  task automatic compare_status(input status_t want);
    check_field("out_valid", 32'(want.out_valid), 32'(out_valid));
    check_field("out_handle", 32'(want.handle), 32'(out_handle));
    check_field("out_size", 32'(want.size), 32'(out_size));
    check_field("changed_flag", 32'(want.changed), 32'(changed_flag));
    check_field("queue_empty", 32'(want.empty), 32'(queue_empty));
    check_field("queued_frames", 32'(want.frames), 32'(queued_frames));
    check_field("queued_bytes", want.bytes, queued_bytes);
    check_field("dropped_now", 32'(want.dropped), 32'(dropped_now));
    check_field("dropped_total", want.drop_count, dropped_total);
    check_field("overflow", 32'(want.overflow), 32'(overflow));
  endtask

  // driver: a held item stays on the wire until taken
  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid && in_stall;
      if (in_valid && !in_stall)
        due_status.push_back(apply_command(on_wire));
      if (!offer && cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        on_wire = cmd_backlog.pop_front();
        command <= on_wire.command;
        frame_handle <= on_wire.handle;
        frame_size <= on_wire.size;
        new_format <= on_wire.fmt;
        offer = 1'b1;
      end
      in_valid <= offer;
    end
  end

  // long receiver hold-off, armed by the sequence
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_req;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (due_status.size() == 0) begin
          fail_count++;
          $display("%0t: result item with nothing expected", $time);
        end else begin
          compare_status(due_status.pop_front());
        end
      end
      res_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == fqd_pkg::REG_DROP_LIMIT)
      budget = val;
    else if (idx == fqd_pkg::REG_DROP_MODE)
      budget_mode = val[1:0];
  endtask

  task automatic configure(input logic [31:0] limit, input logic [1:0] mode);
    write_reg(fqd_pkg::REG_DROP_LIMIT, limit);
    write_reg(fqd_pkg::REG_DROP_MODE, {30'd0, mode});
    @(negedge clk);
  endtask

  task automatic stage(input logic [2:0] cmd, input logic [fqd_pkg::HANDLE_W-1:0] h,
                       input logic [fqd_pkg::SIZE_W-1:0] s,
                       input logic [fqd_pkg::FORMAT_W-1:0] f);
    cmd_item_t it;
    it.command = cmd;
    it.handle = h;
    it.size = s;
    it.fmt = f;
    cmd_backlog.push_back(it);
  endtask

  task automatic stage_random(input int count, input int push_pct, input int size_cap);
    logic [2:0]                   cmd;
    logic [fqd_pkg::SIZE_W-1:0]   s;
    logic [fqd_pkg::FORMAT_W-1:0] f;
    int                           k;
    repeat (count) begin
      if ($urandom_range(99) < push_pct) begin
        cmd = fqd_pkg::CMD_PUSH;
      end else begin
        k = $urandom_range(99);
        if (k < 55)      cmd = fqd_pkg::CMD_POP_OLDEST;
        else if (k < 65) cmd = fqd_pkg::CMD_POP_LATEST;
        else if (k < 78) cmd = fqd_pkg::CMD_SET_FORMAT;
        else if (k < 90) cmd = fqd_pkg::CMD_READ_CHANGE;
        else             cmd = 3'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
      end
      s = ($urandom_range(7) == 0) ? fqd_pkg::SIZE_W'($urandom)
                                   : fqd_pkg::SIZE_W'($urandom_range(0, size_cap));
      // mostly a few codes so repeats of the current format happen
      f = ($urandom_range(3) == 0) ? fqd_pkg::FORMAT_W'($urandom)
                                   : fqd_pkg::FORMAT_W'($urandom_range(0, 2));
      stage(cmd, fqd_pkg::HANDLE_W'($urandom), s, f);
    end
  endtask

  task automatic settle();
    do @(negedge clk); while (cmd_backlog.size() != 0 || in_valid || due_status.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: flag after reset, empty pops, field extremes, formats, unknown codes
    stage(fqd_pkg::CMD_READ_CHANGE, 16'h0, 24'h0, 8'h0);
    stage(fqd_pkg::CMD_READ_CHANGE, 16'hFFFF, 24'hFFFFFF, 8'hFF);
    stage(fqd_pkg::CMD_POP_OLDEST, 16'h0, 24'h0, 8'h0);
    stage(fqd_pkg::CMD_POP_LATEST, 16'h0, 24'h0, 8'h0);
    stage(fqd_pkg::CMD_PUSH, 16'h0000, 24'h000000, 8'h00);
    stage(fqd_pkg::CMD_PUSH, 16'hFFFF, 24'hFFFFFF, 8'hFF);
    stage(fqd_pkg::CMD_POP_OLDEST, 16'h0, 24'h0, 8'h0);
    stage(fqd_pkg::CMD_POP_OLDEST, 16'h0, 24'h0, 8'h0);
    stage(fqd_pkg::CMD_SET_FORMAT, 16'h0, 24'h0, 8'h00);
    stage(fqd_pkg::CMD_SET_FORMAT, 16'h0, 24'h0, 8'hFF);
    stage(fqd_pkg::CMD_READ_CHANGE, 16'h0, 24'h0, 8'h0);
    stage(fqd_pkg::CMD_PUSH, 16'h1234, 24'd100, 8'h0);
    stage(fqd_pkg::CMD_PUSH, 16'hABCD, 24'd300, 8'h0);
    stage(fqd_pkg::CMD_POP_LATEST, 16'h0, 24'h0, 8'h0);
    for (int c = CMD_RESERVED_LO; c <= CMD_RESERVED_HI; c++)
      stage(c[2:0], 16'h5A5A, 24'hA5A5A5, 8'h3C);
    stage(fqd_pkg::CMD_PUSH, 16'h0001, 24'd50, 8'h0);
    stage(fqd_pkg::CMD_SET_FORMAT, 16'h0, 24'h0, 8'h55);
    stage(fqd_pkg::CMD_READ_CHANGE, 16'h0, 24'h0, 8'h0);
    settle();

    // byte limit, including a frame bigger than the whole budget
    configure(32'd1000, fqd_pkg::MODE_BYTES);
    stage(fqd_pkg::CMD_PUSH, 16'h0010, 24'd400, 8'h0);
    stage(fqd_pkg::CMD_PUSH, 16'h0011, 24'd400, 8'h0);
    stage(fqd_pkg::CMD_PUSH, 16'h0012, 24'd400, 8'h0);
    stage(fqd_pkg::CMD_PUSH, 16'h0013, 24'd2000, 8'h0);
    stage(fqd_pkg::CMD_PUSH, 16'h0014, 24'd1000, 8'h0);
    settle();

    configure(32'd3, fqd_pkg::MODE_FRAMES);
    repeat (4) stage(fqd_pkg::CMD_PUSH, fqd_pkg::HANDLE_W'($urandom),
                     fqd_pkg::SIZE_W'($urandom_range(0, 255)), 8'h0);
    settle();

    // random phases
    configure(32'd0, fqd_pkg::MODE_BYTES);
    send_idle_pct = 0; stall_pct = 0;
    stage_random(150, 55, 4095);
    settle();

    configure(32'd20000, fqd_pkg::MODE_BYTES);
    send_idle_pct = 70; stall_pct = 0;
    stage_random(250, 60, 8000);
    settle();

    configure(32'd7, fqd_pkg::MODE_FRAMES);
    send_idle_pct = 0; stall_pct = 70;
    stage_random(250, 60, 4095);
    settle();

    configure($urandom_range(32'h0010_0000, 32'h0400_0000), fqd_pkg::MODE_BYTES);
    send_idle_pct = 13; stall_pct = 13;
    stage_random(250, 60, 24'hFFFFFF);
    settle();

    configure(32'hFFFF_FFFF, fqd_pkg::MODE_FRAMES);
    stage_random(150, 75, 4095);
    settle();

    // receiver held off while pushes keep coming: store fills, input stalls
    configure(32'd0, MODE_OFF);
    send_idle_pct = 0; stall_pct = 0;
    hold_req = hold_req + 1;
    repeat (70) stage(fqd_pkg::CMD_PUSH, fqd_pkg::HANDLE_W'($urandom),
                      fqd_pkg::SIZE_W'($urandom_range(0, 4095)),
                      fqd_pkg::FORMAT_W'($urandom));
    stage_random(130, 70, 4095);
    settle();

    // a tight frame limit on a well-filled queue drops many at once
    configure(32'd1, fqd_pkg::MODE_FRAMES);
    send_idle_pct = 13; stall_pct = 13;
    stage_random(150, 60, 4095);
    settle();

    configure(32'd5, MODE_RESERVED);
    stage_random(100, 60, 4095);
    settle();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/fqd_pkg.sv
rtl/fqd_store.sv
rtl/frame_queue_drop_oldest.sv
sim/frame_queue_drop_oldest_test.sv
